### src/process_ready_queue_macros.svh
// assertion macros for the process ready queue
// no dependencies; included by the files that assert
`ifndef PROCESS_READY_QUEUE_MACROS_SVH
`define PROCESS_READY_QUEUE_MACROS_SVH

// checked outside reset
`define PRQ_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PRQ_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/prq_pkg.sv
// shared types and constants of the process ready queue
// no dependencies
package prq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned NAME_BYTES_DEF  = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NOP    = 2'd3
  } prq_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } prq_status_t;

  typedef struct packed {
    prq_op_t     op;
    logic [63:0] proc_name;
    logic [3:0]  prio;
    logic        is_suspended;
    logic        to_blocked;
  } prq_in_t;

  typedef struct packed {
    prq_status_t status;
    logic        found_in_blocked;
    logic [3:0]  found_prio;
    logic        found_suspended;
    logic        head_valid;
    logic [63:0] head_name;
    logic [3:0]  head_prio;
    logic [4:0]  ready_count;
    logic [4:0]  blocked_count;
  } prq_out_t;

endpackage

### src/process_ready_queue.sv
// Process ready queue: an ordered ready queue and a FIFO blocked queue of named
// entries, each held in its own ram. Pulse start while busy is low to give an
// item; exactly one result follows, shown for one cycle with out_valid high,
// and the receiver cannot hold it off. A blocked insert, a suspended insert, an
// insert into an empty ready queue, a refused insert or a no-op needs no walk;
// an ordered ready insert moves entries towards the tail one by one; a find
// reads entries one by one (ready queue first, then blocked queue); a remove
// does the same search and then moves each entry behind the removed one up. The
// walks are set by the single read port of each ram, walked one entry a cycle.
// No clearing pass after reset.
// depends on prq_pkg, prq_ram and process_ready_queue_macros.svh
`include "process_ready_queue_macros.svh"

module process_ready_queue #(
  parameter int unsigned QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned NAME_BYTES  = prq_pkg::NAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  prq_pkg::prq_in_t  in_item,
  output logic              out_valid,
  output prq_pkg::prq_out_t out_item
);

  localparam int unsigned AW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NAME_W = 8 * NAME_BYTES;
  localparam int unsigned EW     = NAME_W + 5;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_ISHIFT, S_IPUT, S_SRCH, S_CLOSE, S_HEAD, S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  prq_pkg::prq_in_t     req_r, req_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic                 sel_blk_r, sel_blk_nxt;
  logic [CNT_W-1:0]     rlen_r, rlen_nxt;
  logic [CNT_W-1:0]     blen_r, blen_nxt;
  prq_pkg::prq_status_t status_r, status_nxt;
  logic                 f_blk_r, f_blk_nxt;
  logic [3:0]           f_prio_r, f_prio_nxt;
  logic                 f_susp_r, f_susp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  prq_pkg::prq_out_t    out_r, out_nxt;

  logic [AW-1:0]        rd_addr, wr_addr;
  logic [EW-1:0]        wr_data;
  logic                 we_rdy, we_blk;
  logic [EW-1:0]        rdy_rdata, blk_rdata, rd_data;
  logic [NAME_W-1:0]    d_name;
  logic [3:0]           d_prio;
  logic                 d_susp;
  logic [EW-1:0]        ent_in, ent_req;
  logic [CNT_W:0]       k_p1, k_p2, len_sel;
  logic [CNT_W-1:0]     k_m1, k_m2;
  logic                 match;

  // entry storage
  prq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ready_ram (
    .clk(clk), .we(we_rdy), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rdy_rdata)
  );

  prq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_blocked_ram (
    .clk(clk), .we(we_blk), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(blk_rdata)
  );

  // entry packing and read data fields
  assign ent_in  = {in_item.proc_name[NAME_W-1:0], in_item.prio, in_item.is_suspended};
  assign ent_req = {req_r.proc_name[NAME_W-1:0], req_r.prio, req_r.is_suspended};
  assign rd_data = sel_blk_r ? blk_rdata : rdy_rdata;
  assign d_name  = rd_data[EW-1:5];
  assign d_prio  = rd_data[4:1];
  assign d_susp  = rd_data[0];
  assign match   = (d_name == req_r.proc_name[NAME_W-1:0]);

  // walk indices
  assign k_p1    = {1'b0, k_r} + (CNT_W+1)'(1);
  assign k_p2    = {1'b0, k_r} + (CNT_W+1)'(2);
  assign k_m1    = k_r - CNT_W'(1);
  assign k_m2    = k_r - CNT_W'(2);
  assign len_sel = {1'b0, (sel_blk_r ? blen_r : rlen_r)};

  // next state and memory control
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    k_nxt         = k_r;
    sel_blk_nxt   = sel_blk_r;
    rlen_nxt      = rlen_r;
    blen_nxt      = blen_r;
    status_nxt    = status_r;
    f_blk_nxt     = f_blk_r;
    f_prio_nxt    = f_prio_r;
    f_susp_nxt    = f_susp_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_addr       = '0;
    wr_addr       = '0;
    wr_data       = ent_req;
    we_rdy        = 1'b0;
    we_blk        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt     = in_item;
          status_nxt  = prq_pkg::ST_OK;
          f_blk_nxt   = 1'b0;
          f_prio_nxt  = '0;
          f_susp_nxt  = 1'b0;
          sel_blk_nxt = 1'b0;
          k_nxt       = '0;
          state_nxt   = S_HEAD;
          unique case (in_item.op) inside
            prq_pkg::OP_INSERT: begin
              wr_data = ent_in;
              if (in_item.to_blocked) begin
                if (blen_r == FULL_CNT) begin
                  status_nxt = prq_pkg::ST_FULL;
                end else begin
                  we_blk   = 1'b1;
                  wr_addr  = blen_r[AW-1:0];
                  blen_nxt = blen_r + CNT_W'(1);
                end
              end else if (rlen_r == FULL_CNT) begin
                status_nxt = prq_pkg::ST_FULL;
              end else if (in_item.is_suspended || rlen_r == '0) begin
                we_rdy   = 1'b1;
                wr_addr  = rlen_r[AW-1:0];
                rlen_nxt = rlen_r + CNT_W'(1);
              end else begin
                // walk from the tail, moving larger or suspended entries back
                rd_addr   = AW'(rlen_r - CNT_W'(1));
                k_nxt     = rlen_r;
                rlen_nxt  = rlen_r + CNT_W'(1);
                state_nxt = S_ISHIFT;
              end
            end
            prq_pkg::OP_REMOVE, prq_pkg::OP_FIND: begin
              if (rlen_r != '0) begin
                state_nxt = S_SRCH;
              end else if (blen_r != '0) begin
                sel_blk_nxt = 1'b1;
                state_nxt   = S_SRCH;
              end else begin
                status_nxt = prq_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              state_nxt = S_HEAD;
            end
          endcase
        end
      end

      S_ISHIFT: begin
        if (d_susp || (req_r.prio < d_prio)) begin
          we_rdy  = 1'b1;
          wr_addr = k_r[AW-1:0];
          wr_data = rd_data;
          k_nxt   = k_m1;
          if (k_r == CNT_W'(1)) begin
            state_nxt = S_IPUT;
          end else begin
            rd_addr = k_m2[AW-1:0];
          end
        end else begin
          we_rdy    = 1'b1;
          wr_addr   = k_r[AW-1:0];
          state_nxt = S_HEAD;
        end
      end

      S_IPUT: begin
        we_rdy    = 1'b1;
        wr_addr   = '0;
        state_nxt = S_HEAD;
      end

      S_SRCH: begin
        // compare entry k, read entry k + 1 ahead
        rd_addr = k_p1[AW-1:0];
        if (match) begin
          f_blk_nxt  = sel_blk_r;
          f_prio_nxt = d_prio;
          f_susp_nxt = d_susp;
          state_nxt  = S_HEAD;
          if (req_r.op == prq_pkg::OP_REMOVE) begin
            if (k_p1 < len_sel) begin
              state_nxt = S_CLOSE;
            end else if (sel_blk_r) begin
              blen_nxt = blen_r - CNT_W'(1);
            end else begin
              rlen_nxt = rlen_r - CNT_W'(1);
            end
          end
        end else if (k_p1 < len_sel) begin
          k_nxt = k_p1[CNT_W-1:0];
        end else if (!sel_blk_r && blen_r != '0) begin
          sel_blk_nxt = 1'b1;
          k_nxt       = '0;
          rd_addr     = '0;
        end else begin
          status_nxt = prq_pkg::ST_NOT_FOUND;
          state_nxt  = S_HEAD;
        end
      end

      S_CLOSE: begin
        // move entry k + 1 up to k
        we_rdy  = !sel_blk_r;
        we_blk  = sel_blk_r;
        wr_addr = k_r[AW-1:0];
        wr_data = rd_data;
        rd_addr = k_p2[AW-1:0];
        if (k_p2 < len_sel) begin
          k_nxt = k_p1[CNT_W-1:0];
        end else begin
          if (sel_blk_r) begin
            blen_nxt = blen_r - CNT_W'(1);
          end else begin
            rlen_nxt = rlen_r - CNT_W'(1);
          end
          state_nxt = S_HEAD;
        end
      end

      S_HEAD: begin
        rd_addr   = '0;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        out_valid_nxt            = 1'b1;
        out_nxt.status           = status_r;
        out_nxt.found_in_blocked = f_blk_r;
        out_nxt.found_prio       = f_prio_r;
        out_nxt.found_suspended  = f_susp_r;
        out_nxt.head_valid       = (rlen_r != '0);
        out_nxt.head_name        = (rlen_r != '0) ? 64'(rdy_rdata[EW-1:5]) : '0;
        out_nxt.head_prio        = (rlen_r != '0) ? rdy_rdata[4:1] : '0;
        out_nxt.ready_count      = 5'(rlen_r);
        out_nxt.blocked_count    = 5'(blen_r);
        state_nxt                = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, lengths and registered outputs
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    k_r        <= k_nxt;
    sel_blk_r  <= sel_blk_nxt;
    status_r   <= status_nxt;
    f_blk_r    <= f_blk_nxt;
    f_prio_r   <= f_prio_nxt;
    f_susp_r   <= f_susp_nxt;
    out_r      <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rlen_r      <= '0;
      blen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rlen_r      <= rlen_nxt;
      blen_r      <= blen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // checks
  `PRQ_ASSERT_CLK(a_strobe_single, out_valid_r |=> !out_valid_r, "result strobe longer than one cycle")
  `PRQ_ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted item did not make block busy")
  `PRQ_ASSERT_CLK(a_result_idle, out_valid_r |-> (state_r == S_IDLE), "result shown while not idle")
  `PRQ_ASSERT_CLK(a_len_bound, (rlen_r <= FULL_CNT) && (blen_r <= FULL_CNT), "queue length beyond depth")
  `PRQ_ASSERT_CLK(a_one_write, !(we_rdy && we_blk), "both queues written in one cycle")
  `PRQ_ASSERT_ALL(a_reset_quiet, !rst_n |=> !out_valid_r, "result strobe after reset")

endmodule

### src/prq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module prq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/process_ready_queue_test.sv
// testbench for process_ready_queue: directed and random insert, remove and find items
// checked against an in-bench model of both queues; depends on prq_pkg and the block
module process_ready_queue_test;

  localparam int DEPTH = prq_pkg::QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  prq_pkg::prq_in_t  in_item;
  logic              out_valid;
  prq_pkg::prq_out_t out_item;

  process_ready_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // model copy of both queues
  logic [63:0] rdy_name [DEPTH];
  logic [3:0]  rdy_prio [DEPTH];
  logic        rdy_susp [DEPTH];
  int          rdy_len;
  logic [63:0] blk_name [DEPTH];
  logic [3:0]  blk_prio [DEPTH];
  logic        blk_susp [DEPTH];
  int          blk_len;

  prq_pkg::prq_out_t pending_results[$];
  logic [63:0] name_pool[8];
  int          items_sent;
  int          results_seen;
  int          fail_count;
  int          full_refusals;
  int          cycle_count;

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("process_ready_queue_test NOT OK");
      $finish;
    end
  end

  // work out the result of one item and update the queue copy
  task automatic queue_update(input prq_pkg::prq_in_t it, output prq_pkg::prq_out_t r);
    int pos;
    int k;
    bit hit;
    r = '0;
    r.status = prq_pkg::ST_OK;
    hit = 1'b0;
    if (it.op == prq_pkg::OP_INSERT) begin
      if (it.to_blocked) begin
        if (blk_len >= DEPTH) begin
          r.status = prq_pkg::ST_FULL;
        end else begin
          blk_name[blk_len] = it.proc_name;
          blk_prio[blk_len] = it.prio;
          blk_susp[blk_len] = it.is_suspended;
          blk_len++;
        end
      end else if (rdy_len >= DEPTH) begin
        r.status = prq_pkg::ST_FULL;
      end else begin
        pos = rdy_len;
        if (!it.is_suspended) begin
          for (pos = 0; pos < rdy_len; pos++)
            if (it.prio < rdy_prio[pos] || rdy_susp[pos]) break;
        end
        for (k = rdy_len; k > pos; k--) begin
          rdy_name[k] = rdy_name[k-1];
          rdy_prio[k] = rdy_prio[k-1];
          rdy_susp[k] = rdy_susp[k-1];
        end
        rdy_name[pos] = it.proc_name;
        rdy_prio[pos] = it.prio;
        rdy_susp[pos] = it.is_suspended;
        rdy_len++;
      end
      if (r.status == prq_pkg::ST_FULL) full_refusals++;
    end else if (it.op == prq_pkg::OP_REMOVE || it.op == prq_pkg::OP_FIND) begin
      // ready queue first, then blocked
      for (pos = 0; pos < rdy_len; pos++)
        if (rdy_name[pos] == it.proc_name) begin
          hit = 1'b1;
          break;
        end
      if (hit) begin
        r.found_prio = rdy_prio[pos];
        r.found_suspended = rdy_susp[pos];
        if (it.op == prq_pkg::OP_REMOVE) begin
          for (k = pos; k + 1 < rdy_len; k++) begin
            rdy_name[k] = rdy_name[k+1];
            rdy_prio[k] = rdy_prio[k+1];
            rdy_susp[k] = rdy_susp[k+1];
          end
          rdy_len--;
        end
      end else begin
        for (pos = 0; pos < blk_len; pos++)
          if (blk_name[pos] == it.proc_name) begin
            hit = 1'b1;
            break;
          end
        if (hit) begin
          r.found_in_blocked = 1'b1;
          r.found_prio = blk_prio[pos];
          r.found_suspended = blk_susp[pos];
          if (it.op == prq_pkg::OP_REMOVE) begin
            for (k = pos; k + 1 < blk_len; k++) begin
              blk_name[k] = blk_name[k+1];
              blk_prio[k] = blk_prio[k+1];
              blk_susp[k] = blk_susp[k+1];
            end
            blk_len--;
          end
        end else begin
          r.status = prq_pkg::ST_NOT_FOUND;
        end
      end
    end
    if (rdy_len > 0) begin
      r.head_valid = 1'b1;
      r.head_name = rdy_name[0];
      r.head_prio = rdy_prio[0];
    end
    r.ready_count = rdy_len[4:0];
    r.blocked_count = blk_len[4:0];
  endtask

  // give one item, called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input prq_pkg::prq_in_t it);
    prq_pkg::prq_out_t r;
    start <= 1'b1;
    in_item <= it;
    while (busy) @(negedge clk);
    @(posedge clk);
    queue_update(it, r);
    pending_results.push_back(r);
    items_sent++;
    @(negedge clk);
  endtask

  // hold start low for an idle gap, if n is above zero
  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic prq_pkg::prq_in_t make_item(prq_pkg::prq_op_t op, logic [63:0] nm,
                                                 logic [3:0] p, logic s, logic b);
    prq_pkg::prq_in_t it;
    it.op = op;
    it.proc_name = nm;
    it.prio = p;
    it.is_suspended = s;
    it.to_blocked = b;
    return it;
  endfunction

  task automatic check_field(input string fname, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    prq_pkg::prq_out_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, out_item);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, out_item.status);
        check_field("found_in_blocked", e.found_in_blocked, out_item.found_in_blocked);
        check_field("found_prio", e.found_prio, out_item.found_prio);
        check_field("found_suspended", e.found_suspended, out_item.found_suspended);
        check_field("head_valid", e.head_valid, out_item.head_valid);
        check_field("head_name", e.head_name, out_item.head_name);
        check_field("head_prio", e.head_prio, out_item.head_prio);
        check_field("ready_count", e.ready_count, out_item.ready_count);
        check_field("blocked_count", e.blocked_count, out_item.blocked_count);
      end
    end
  end

  // find and remove on empty queues, no-op on empty
  task automatic test_empty_queues();
    send_item(make_item(prq_pkg::OP_FIND, 64'h0, 4'h0, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_REMOVE, name_pool[0], 4'h0, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_NOP, 64'hffff_ffff_ffff_ffff, 4'hf, 1'b1, 1'b1));
  endtask

  // ordering: equal priorities fifo, suspended at tail, extremes of priority
  task automatic test_ready_order();
    send_item(make_item(prq_pkg::OP_INSERT, name_pool[0], 4'h5, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_INSERT, name_pool[1], 4'h5, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_INSERT, name_pool[2], 4'hf, 1'b1, 1'b0));
    send_item(make_item(prq_pkg::OP_INSERT, name_pool[3], 4'hf, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_INSERT, 64'hffff_ffff_ffff_ffff, 4'h0, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_INSERT, 64'h0, 4'h0, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_FIND, name_pool[2], 4'h0, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_REMOVE, 64'hffff_ffff_ffff_ffff, 4'h0, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_REMOVE, name_pool[1], 4'h0, 1'b0, 1'b0));
  endtask

  // blocked fifo, duplicate names across queues, search order
  task automatic test_blocked_fifo();
    send_item(make_item(prq_pkg::OP_INSERT, name_pool[4], 4'h3, 1'b1, 1'b1));
    send_item(make_item(prq_pkg::OP_INSERT, name_pool[4], 4'h9, 1'b0, 1'b1));
    send_item(make_item(prq_pkg::OP_INSERT, name_pool[0], 4'h7, 1'b0, 1'b1));
    send_item(make_item(prq_pkg::OP_FIND, name_pool[0], 4'h0, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_REMOVE, name_pool[0], 4'h0, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_FIND, name_pool[0], 4'h0, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_REMOVE, name_pool[4], 4'h0, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_FIND, name_pool[4], 4'h0, 1'b0, 1'b0));
    send_item(make_item(prq_pkg::OP_NOP, 64'h0, 4'h0, 1'b0, 1'b0));
  endtask

  // random traffic; insert weight steers the queues towards full or empty
  task automatic test_random_traffic(input int count, input int insert_pct,
                                     input bit with_gaps);
    prq_pkg::prq_in_t it;
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) it.op = prq_pkg::OP_INSERT;
      else if (r < insert_pct + (100 - insert_pct) / 2) it.op = prq_pkg::OP_REMOVE;
      else if (r < 97) it.op = prq_pkg::OP_FIND;
      else it.op = prq_pkg::OP_NOP;
      if ($urandom_range(0, 9) < 8) it.proc_name = name_pool[$urandom_range(0, 7)];
      else it.proc_name = {$urandom, $urandom};
      it.prio = 4'($urandom_range(0, 15));
      it.is_suspended = ($urandom_range(0, 3) == 0);
      it.to_blocked = 1'($urandom_range(0, 1));
      send_item(it);
      if (with_gaps) idle_for(gap_len());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    rdy_len = 0;
    blk_len = 0;
    items_sent = 0;
    results_seen = 0;
    fail_count = 0;
    full_refusals = 0;
    cycle_count = 0;
    for (int i = 0; i < 8; i++) name_pool[i] = {$urandom, $urandom};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_queues();
    test_ready_order();
    idle_for(5);
    test_blocked_fifo();
    test_random_traffic(350, 85, 1'b1);
    test_random_traffic(300, 20, 1'b1);
    test_random_traffic(150, 50, 1'b0);
    test_random_traffic(350, 90, 1'b1);
    test_random_traffic(200, 10, 1'b0);
    idle_for(1);

    // drain
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("covered %0d items and %0d results, %0d refused as full",
             items_sent, results_seen, full_refusals);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("process_ready_queue_test OK");
    end else begin
      $display("process_ready_queue_test NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/prq_pkg.sv
src/prq_ram.sv
src/process_ready_queue.sv
tb/process_ready_queue_test.sv
